// ===== hw/rtl/linear_array_deque_assert.svh =====
// Assertion macros used by the deque top level.
// Each macro takes a label, a clock, an active-low reset, a condition,
// a consequence and a message.
`ifndef LINEAR_ARRAY_DEQUE_ASSERT_SVH
`define LINEAR_ARRAY_DEQUE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define LAD_ASSERT_SAME(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define LAD_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lad_pkg.sv =====
`timescale 1ns / 1ps

package lad_pkg;

  localparam int unsigned KindWidth   = 3;
  localparam int unsigned StatusWidth = 3;
  localparam int unsigned DataWidth   = 32;

  typedef enum logic [KindWidth-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_PEEK_FRONT = 3'd4,
    KIND_PEEK_BACK  = 3'd5
  } kind_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK       = 3'd0,
    STATUS_FULL     = 3'd1,
    STATUS_NO_FRONT = 3'd2,
    STATUS_NO_BACK  = 3'd3,
    STATUS_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the item and start the entry read
    logic execute;  // apply the operation and load the result register
  } cmd_t;

endpackage

// ===== hw/rtl/lad_ctrl.sv =====
`timescale 1ns / 1ps

module lad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lad_pkg::cmd_t cmd_o
);

  lad_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lad_pkg::CTRL_IDLE: begin
        if (in_valid_i) begin
          state_d = lad_pkg::CTRL_EXEC;
        end
      end
      lad_pkg::CTRL_EXEC: begin
        if (slot_free) begin
          state_d = lad_pkg::CTRL_IDLE;
        end
      end
      default: state_d = lad_pkg::CTRL_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      lad_pkg::CTRL_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lad_pkg::CTRL_EXEC: begin
        cmd_o.execute = slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // The result register is full from an execute until the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.execute) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lad_pkg::CTRL_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/lad_datapath.sv =====
`timescale 1ns / 1ps

module lad_datapath #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lad_pkg::cmd_t                          cmd_i,
  input  logic [lad_pkg::KindWidth-1:0]          in_kind_i,
  input  logic signed [lad_pkg::DataWidth-1:0]   in_value_i,
  output logic [lad_pkg::StatusWidth-1:0]        out_status_o,
  output logic signed [lad_pkg::DataWidth-1:0]   out_data_o
);

  localparam int unsigned AddrWidth = $clog2(DEPTH);
  localparam logic [AddrWidth-1:0] LastIdx = AddrWidth'(DEPTH - 1);
  localparam logic [AddrWidth-1:0] ZeroIdx = '0;

  logic [lad_pkg::DataWidth-1:0] mem_q [DEPTH];

  logic [AddrWidth-1:0]               head_q, head_d, tail_q, tail_d, rd_addr, wr_addr;
  logic                               empty_q, empty_d, wr_en, full;
  logic [lad_pkg::KindWidth-1:0]      kind_q;
  logic [lad_pkg::DataWidth-1:0]      value_q, rdata_q, res_data_d, res_data_q;
  lad_pkg::status_e                   res_status_d, res_status_q;

  // Front reads use the head, everything else the tail.
  always_comb begin
    rd_addr = tail_q;
    if (in_kind_i == lad_pkg::KIND_POP_FRONT || in_kind_i == lad_pkg::KIND_PEEK_FRONT) begin
      rd_addr = head_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= in_kind_i;
      value_q <= in_value_i;
      rdata_q <= mem_q[rd_addr];
    end
    if (wr_en) begin
      mem_q[wr_addr] <= value_q;
    end
  end

  assign full = !empty_q && head_q == ZeroIdx && tail_q == LastIdx;

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    empty_d      = empty_q;
    wr_en        = 1'b0;
    wr_addr      = ZeroIdx;
    res_status_d = lad_pkg::STATUS_OK;
    res_data_d   = '0;
    case (kind_q)
      lad_pkg::KIND_PUSH_FRONT, lad_pkg::KIND_PUSH_BACK: begin
        if (full) begin
          res_status_d = lad_pkg::STATUS_FULL;
        end else if (empty_q) begin
          empty_d = 1'b0;
          head_d  = ZeroIdx;
          tail_d  = ZeroIdx;
          wr_en   = 1'b1;
          wr_addr = ZeroIdx;
        end else if (kind_q == lad_pkg::KIND_PUSH_FRONT) begin
          if (head_q == ZeroIdx) begin
            res_status_d = lad_pkg::STATUS_NO_FRONT;
          end else begin
            head_d  = head_q - 1'b1;
            wr_en   = 1'b1;
            wr_addr = head_q - 1'b1;
          end
        end else begin
          if (tail_q == LastIdx) begin
            res_status_d = lad_pkg::STATUS_NO_BACK;
          end else begin
            tail_d  = tail_q + 1'b1;
            wr_en   = 1'b1;
            wr_addr = tail_q + 1'b1;
          end
        end
      end
      lad_pkg::KIND_POP_FRONT, lad_pkg::KIND_POP_BACK,
      lad_pkg::KIND_PEEK_FRONT, lad_pkg::KIND_PEEK_BACK: begin
        if (empty_q) begin
          res_status_d = lad_pkg::STATUS_EMPTY;
        end else begin
          res_data_d = rdata_q;
          if (kind_q == lad_pkg::KIND_POP_FRONT || kind_q == lad_pkg::KIND_POP_BACK) begin
            if (head_q == tail_q) begin
              empty_d = 1'b1;
              head_d  = ZeroIdx;
              tail_d  = ZeroIdx;
            end else if (kind_q == lad_pkg::KIND_POP_FRONT) begin
              head_d = head_q + 1'b1;
            end else begin
              tail_d = tail_q - 1'b1;
            end
          end
        end
      end
      default: begin
        res_status_d = lad_pkg::STATUS_OK;
      end
    endcase
    if (!cmd_i.execute) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= ZeroIdx;
      tail_q  <= ZeroIdx;
      empty_q <= 1'b1;
    end else if (cmd_i.execute) begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_status_q <= res_status_d;
      res_data_q   <= res_data_d;
    end
  end

  assign out_status_o = res_status_q;
  assign out_data_o   = res_data_q;

endmodule

// ===== hw/rtl/linear_array_deque.sv =====
// out_valid_o rises from the execute step that follows the accepting edge,
// which waits while an earlier result is still waiting at the output.
// A new item is accepted only after the previous one has executed: each item
// passes the registered read of the entry memory, then the operation step.
// Reset clears the head and tail indices and sets the empty flag; the entry
// memory is not cleared, since only written entries are ever used.
`timescale 1ns / 1ps

`include "linear_array_deque_assert.svh"

module linear_array_deque #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [lad_pkg::KindWidth-1:0]        in_kind_i,
  input  logic signed [lad_pkg::DataWidth-1:0] in_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [lad_pkg::StatusWidth-1:0]      out_status_o,
  output logic signed [lad_pkg::DataWidth-1:0] out_data_o
);

  // The controller sequences each item through two steps: capture, where the
  // item is latched and the entry at the addressed end is read, and execute,
  // where the status is decided, the indices move and a pushed word is
  // written. Execute waits while the result register still holds an item
  // that has not been taken, so no result is ever overwritten.
  lad_pkg::cmd_t cmd;

  lad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  // The datapath owns the entry memory, the head and tail indices, the
  // empty flag and the result register. A new item may be captured while
  // the previous result is still waiting at the output.
  lad_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_kind_i   (in_kind_i),
    .in_value_i  (in_value_i),
    .out_status_o(out_status_o),
    .out_data_o  (out_data_o)
  );

  // Only one item is in flight: after an accept the input side closes.
  `LAD_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o,
                   "item accepted while another is in flight")

  // Error statuses always carry a zero data word.
  `LAD_ASSERT_SAME(a_err_data_zero, clk_i, rst_ni,
                   out_valid_o && out_status_o != lad_pkg::STATUS_OK, out_data_o == '0,
                   "error result with nonzero data")

  // A new result appears only from the execute step, when input is closed.
  `LAD_ASSERT_SAME(a_result_from_exec, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o),
                   "result appeared without an item in execution")

endmodule
